// ===== rtl/core/predictive_yaw_rotation_controller_unit_defines.svh =====
// assertion macros for the checker file
`ifndef PREDICTIVE_YAW_ROTATION_CONTROLLER_UNIT_DEFINES_SVH
`define PREDICTIVE_YAW_ROTATION_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PYRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, sampled on clk, off during rst
`define PYRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/core/pyrc_pkg.sv =====
package pyrc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CORDIC_W = 36;
  localparam int ANG_W = 26;
  localparam int PADDR_W = 5;

  localparam logic [12:0] MIN_RATE_Q16 = 13'd6836;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] HALF_TURN = 16'h8000;
  localparam logic signed [ANG_W-1:0] CORDIC_QUARTER = ANG_W'(1) << 22;
  localparam logic signed [ANG_W-1:0] CORDIC_ROUND = ANG_W'(128);

  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_PRESS   = 2'd1,
    KEY_RELEASE = 2'd2
  } key_action_t;

  typedef enum logic [3:0] {
    STAT_IDLE        = 4'd0,
    STAT_ARMED       = 4'd1,
    STAT_ROTATING    = 4'd2,
    STAT_ARRIVED     = 4'd3,
    STAT_OVERSHOT    = 4'd4,
    STAT_TIMEOUT     = 4'd5,
    STAT_CAMERA_LOST = 4'd6,
    STAT_YAW_FAULT   = 4'd7,
    STAT_SKIP_NOCAM  = 4'd8,
    STAT_SKIP_NOYAW  = 4'd9,
    STAT_SKIP_NOPOS  = 4'd10,
    STAT_AT_TARGET   = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    CFG_LOOKAHEAD = 3'd0,
    CFG_TOLERANCE = 3'd1,
    CFG_TIMEOUT   = 3'd2,
    CFG_OVERSHOOT = 3'd3,
    CFG_COINCIDE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TGT_CARDINAL = 2'd0,
    TGT_BEARING  = 2'd1,
    TGT_ZERO     = 2'd2
  } tgt_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_DECODE  = 4'd1,
    ST_TRACK   = 4'd2,
    ST_PRODUCT = 4'd3,
    ST_DECIDE  = 4'd4,
    ST_OFFSET  = 4'd5,
    ST_PREROT  = 4'd6,
    ST_ROTATE  = 4'd7,
    ST_ROUND   = 4'd8,
    ST_AIM     = 4'd9,
    ST_FINISH  = 4'd10
  } state_t;

  typedef struct packed {
    logic               hotkey_pressed;
    logic               camera_present;
    logic               yaw_valid;
    logic [15:0]        current_yaw;
    logic [31:0]        now_ms;
    logic               beacon_target_valid;
    logic               player_pos_valid;
    logic signed [31:0] waypoint_x;
    logic signed [31:0] waypoint_y;
    logic signed [31:0] player_x;
    logic signed [31:0] player_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  key_action;
    logic        key_clockwise;
    logic [3:0]  status;
    logic        rotation_active;
    logic [15:0] target_yaw;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  lookahead_ms;
    logic [12:0] arrival_tolerance;
    logic [15:0] timeout_ms;
    logic [14:0] overshoot_margin;
    logic [15:0] coincide_limit;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              track;
    logic              product;
    logic              commit_track;
    logic              clear_active;
    logic              offset;
    logic              prerot;
    logic              rotate;
    logic              tgt_load;
    tgt_sel_t          tgt_sel;
    logic              arm;
    logic              res_load;
    key_action_t       res_action;
    status_t           res_status;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic hotkey;
    logic camera;
    logic yaw_ok;
    logic beacon;
    logic pos_ok;
    logic arrived;
    logic overshot;
    logic timed;
    logic coincident;
    logic zero_offset;
    logic within_tol;
  } dp_sts_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] idx);
    logic [21:0] e;
    unique case (idx)
      5'd0:  e = 22'd2097152;
      5'd1:  e = 22'd1238021;
      5'd2:  e = 22'd654136;
      5'd3:  e = 22'd332050;
      5'd4:  e = 22'd166669;
      5'd5:  e = 22'd83416;
      5'd6:  e = 22'd41718;
      5'd7:  e = 22'd20860;
      5'd8:  e = 22'd10430;
      5'd9:  e = 22'd5215;
      5'd10: e = 22'd2608;
      5'd11: e = 22'd1304;
      5'd12: e = 22'd652;
      5'd13: e = 22'd326;
      5'd14: e = 22'd163;
      5'd15: e = 22'd81;
      5'd16: e = 22'd41;
      5'd17: e = 22'd20;
      5'd18: e = 22'd10;
      5'd19: e = 22'd5;
      5'd20: e = 22'd3;
      5'd21: e = 22'd1;
      5'd22: e = 22'd1;
      default: e = 22'd0;
    endcase
    return e;
  endfunction

  // magnitude of a wrapped angle difference, half turn counts positive
  function automatic logic [15:0] angle_abs(input logic [15:0] d);
    return (d > HALF_TURN) ? 16'(16'h0 - d) : d;
  endfunction

  function automatic logic angle_pos(input logic [15:0] d);
    return (d != 16'h0) && (d <= HALF_TURN);
  endfunction

endpackage

// ===== rtl/core/pyrc_cfg.sv =====
module pyrc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pyrc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output pyrc_pkg::cfg_t                 cfg
);
  import pyrc_pkg::*;

  cfg_reg_t widx;
  logic     wr;

  assign widx = cfg_reg_t'(paddr[PADDR_W-1:2]);
  assign wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead_ms      <= 10'd40;
      cfg.arrival_tolerance <= 13'd522;
      cfg.timeout_ms        <= 16'd3000;
      cfg.overshoot_margin  <= 15'd8192;
      cfg.coincide_limit    <= 16'd7;
    end else if (wr) begin
      unique case (widx)
        CFG_LOOKAHEAD: cfg.lookahead_ms      <= pwdata[9:0];
        CFG_TOLERANCE: cfg.arrival_tolerance <= pwdata[12:0];
        CFG_TIMEOUT:   cfg.timeout_ms        <= pwdata[15:0];
        CFG_OVERSHOOT: cfg.overshoot_margin  <= pwdata[14:0];
        CFG_COINCIDE:  cfg.coincide_limit    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      CFG_LOOKAHEAD: prdata = {22'b0, cfg.lookahead_ms};
      CFG_TOLERANCE: prdata = {19'b0, cfg.arrival_tolerance};
      CFG_TIMEOUT:   prdata = {16'b0, cfg.timeout_ms};
      CFG_OVERSHOOT: prdata = {17'b0, cfg.overshoot_margin};
      CFG_COINCIDE:  prdata = {16'b0, cfg.coincide_limit};
      default:       prdata = 32'b0;
    endcase
  end

endmodule

// ===== rtl/core/pyrc_dp.sv =====
module pyrc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pyrc_pkg::cfg_t       cfg,
  input  pyrc_pkg::in_item_t   item,
  input  pyrc_pkg::dp_cmd_t    cmd,
  output pyrc_pkg::dp_sts_t    sts,
  output pyrc_pkg::out_item_t  result
);
  import pyrc_pkg::*;

  in_item_t item_q;

  // rotation state
  logic        active;
  logic        held_cw;
  logic [15:0] target_angle;
  logic [15:0] init_abs;
  logic [31:0] start_time;
  logic [15:0] prev_yaw;
  logic [31:0] prev_time;

  // tracking pipeline
  logic [15:0] arem_q;
  logic [15:0] ady_q;
  logic [31:0] dt_q;
  logic        dt_nz_q;
  logic        dir_ok_q;
  logic        arr_static_q;
  logic        overshot_q;
  logic        timed_q;
  logic [44:0] prod_rate;
  logic [47:0] prod_rem;
  logic [25:0] prod_la;

  // bearing unit
  logic signed [32:0]         dx_q;
  logic signed [32:0]         dy_q;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [ANG_W-1:0]    cang;
  logic [15:0]                tgt_q;

  key_action_t res_action;
  status_t     res_status;

  logic [15:0]                rem_d;
  logic [15:0]                dyaw_d;
  logic [31:0]                dt_d;
  logic [31:0]                elapsed;
  logic [15:0]                arem_d;
  logic [15:0]                ady_d;
  logic [16:0]                overshoot_lim;
  logic                       rate_ok;
  logic                       predict;
  logic [32:0]                adx;
  logic [32:0]                ady_off;
  logic signed [CORDIC_W-1:0] dx_ext;
  logic signed [CORDIC_W-1:0] dy_ext;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [ANG_W-1:0]    atan_d;
  logic signed [ANG_W-1:0]    angle_sum;
  logic [15:0]                compass;
  logic [1:0]                 next_sector;
  logic [1:0]                 card_code;
  logic [15:0]                tgt_card;
  logic [15:0]                aim_d;
  logic [15:0]                aim_abs;
  logic                       aim_pos;

  assign rem_d         = target_angle - item_q.current_yaw;
  assign dyaw_d        = item_q.current_yaw - prev_yaw;
  assign dt_d          = item_q.now_ms - prev_time;
  assign elapsed       = item_q.now_ms - start_time;
  assign arem_d        = angle_abs(rem_d);
  assign ady_d         = angle_abs(dyaw_d);
  assign overshoot_lim = {1'b0, init_abs} + {2'b0, cfg.overshoot_margin};

  assign rate_ok = {13'b0, ady_q, 16'b0} >= prod_rate;
  assign predict = prod_rem <= {22'b0, prod_la};

  assign adx     = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady_off = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign dx_ext  = {{(CORDIC_W-33){dx_q[32]}}, dx_q};
  assign dy_ext  = {{(CORDIC_W-33){dy_q[32]}}, dy_q};

  assign xs        = cx >>> cmd.step;
  assign ys        = cy >>> cmd.step;
  assign atan_d    = $signed({{(ANG_W-22){1'b0}}, atan_entry(5'(cmd.step))});
  assign angle_sum = cang + CORDIC_ROUND;

  // next clockwise cardinal
  assign compass     = QUARTER_TURN - item_q.current_yaw;
  assign next_sector = compass[15:14] + 2'd1;
  assign card_code   = 2'b01 - next_sector;
  assign tgt_card    = {card_code, 14'b0};

  assign aim_d   = tgt_q - item_q.current_yaw;
  assign aim_abs = angle_abs(aim_d);
  assign aim_pos = angle_pos(aim_d);

  always_comb begin
    sts.active      = active;
    sts.hotkey      = item_q.hotkey_pressed;
    sts.camera      = item_q.camera_present;
    sts.yaw_ok      = item_q.yaw_valid;
    sts.beacon      = item_q.beacon_target_valid;
    sts.pos_ok      = item_q.player_pos_valid;
    sts.arrived     = (dt_nz_q && rate_ok && dir_ok_q) ? predict : arr_static_q;
    sts.overshot    = overshot_q;
    sts.timed       = timed_q;
    sts.coincident  = (adx < {17'b0, cfg.coincide_limit}) &&
                      (ady_off < {17'b0, cfg.coincide_limit});
    sts.zero_offset = (dx_q == 33'sd0) && (dy_q == 33'sd0);
    sts.within_tol  = aim_abs <= {3'b0, cfg.arrival_tolerance};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      held_cw      <= 1'b0;
      target_angle <= 16'h0;
      init_abs     <= 16'h0;
      start_time   <= 32'h0;
      prev_yaw     <= 16'h0;
      prev_time    <= 32'h0;
    end else begin
      if (cmd.clear_active) begin
        active <= 1'b0;
      end
      if (cmd.commit_track) begin
        prev_yaw  <= item_q.current_yaw;
        prev_time <= item_q.now_ms;
      end
      if (cmd.arm) begin
        active       <= 1'b1;
        held_cw      <= !aim_pos;
        target_angle <= tgt_q;
        init_abs     <= aim_abs;
        start_time   <= item_q.now_ms;
        prev_yaw     <= item_q.current_yaw;
        prev_time    <= item_q.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.track) begin
      arem_q       <= arem_d;
      ady_q        <= ady_d;
      dt_q         <= dt_d;
      dt_nz_q      <= dt_d != 32'h0;
      dir_ok_q     <= angle_pos(rem_d) == angle_pos(dyaw_d);
      arr_static_q <= arem_d <= {3'b0, cfg.arrival_tolerance};
      overshot_q   <= {1'b0, arem_d} > overshoot_lim;
      timed_q      <= elapsed >= {16'b0, cfg.timeout_ms};
    end
    if (cmd.product) begin
      prod_rate <= {13'b0, dt_q} * {32'b0, MIN_RATE_Q16};
      prod_rem  <= {16'b0, dt_q} * {32'b0, arem_q};
      prod_la   <= {16'b0, cfg.lookahead_ms} * {10'b0, ady_q};
    end
    if (cmd.offset) begin
      dx_q <= {item_q.waypoint_x[31], item_q.waypoint_x} -
              {item_q.player_x[31], item_q.player_x};
      dy_q <= {item_q.waypoint_y[31], item_q.waypoint_y} -
              {item_q.player_y[31], item_q.player_y};
    end
    if (cmd.prerot) begin
      if (dx_q[32]) begin
        if (!dy_q[32]) begin
          cx   <= dy_ext;
          cy   <= -dx_ext;
          cang <= CORDIC_QUARTER;
        end else begin
          cx   <= -dy_ext;
          cy   <= dx_ext;
          cang <= -CORDIC_QUARTER;
        end
      end else begin
        cx   <= dx_ext;
        cy   <= dy_ext;
        cang <= '0;
      end
    end else if (cmd.rotate) begin
      if (cy > 0) begin
        cx   <= cx + ys;
        cy   <= cy - xs;
        cang <= cang + atan_d;
      end else begin
        cx   <= cx - ys;
        cy   <= cy + xs;
        cang <= cang - atan_d;
      end
    end
    if (cmd.tgt_load) begin
      unique case (cmd.tgt_sel)
        TGT_CARDINAL: tgt_q <= tgt_card;
        TGT_BEARING:  tgt_q <= angle_sum[23:8];
        TGT_ZERO:     tgt_q <= 16'h0;
        default:      tgt_q <= 16'h0;
      endcase
    end
    if (cmd.res_load) begin
      res_action <= cmd.res_action;
      res_status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      result.key_action      <= res_action;
      result.key_clockwise   <= held_cw;
      result.status          <= res_status;
      result.rotation_active <= active;
      result.target_yaw      <= target_angle;
    end
  end

endmodule

// ===== rtl/core/pyrc_ctrl.sv =====
module pyrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  pyrc_pkg::dp_sts_t   sts,
  output pyrc_pkg::dp_cmd_t   cmd
);
  import pyrc_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              result_valid_next;
  logic              last_step;
  logic              release_now;
  logic              out_free;

  assign last_step   = step == STEP_W'(CORDIC_STEPS - 1);
  assign release_now = sts.arrived || sts.overshot || sts.timed;
  assign out_free    = !result_valid || !result_stall;
  assign item_stall  = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (sts.active) begin
          state_next = (sts.camera && sts.yaw_ok) ? ST_TRACK : ST_FINISH;
        end else if (!sts.hotkey || !sts.camera || !sts.yaw_ok) begin
          state_next = ST_FINISH;
        end else if (sts.beacon) begin
          state_next = sts.pos_ok ? ST_OFFSET : ST_FINISH;
        end else begin
          state_next = ST_AIM;
        end
      end
      ST_TRACK:   state_next = ST_PRODUCT;
      ST_PRODUCT: state_next = ST_DECIDE;
      ST_DECIDE:  state_next = ST_FINISH;
      ST_OFFSET:  state_next = ST_PREROT;
      ST_PREROT: begin
        priority if (sts.coincident) state_next = ST_FINISH;
        else if (sts.zero_offset)    state_next = ST_AIM;
        else                         state_next = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (last_step) state_next = ST_ROUND;
      end
      ST_ROUND:  state_next = ST_AIM;
      ST_AIM:    state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd               = '0;
    cmd.step          = step;
    step_next         = step;
    result_valid_next = (result_valid && !result_stall) ? 1'b0 : result_valid;
    unique case (state)
      ST_IDLE: begin
        cmd.load = item_valid;
      end
      ST_DECODE: begin
        priority if (sts.active) begin
          if (!(sts.camera && sts.yaw_ok)) begin
            cmd.clear_active = 1'b1;
            cmd.res_load     = 1'b1;
            cmd.res_action   = KEY_RELEASE;
            cmd.res_status   = sts.camera ? STAT_YAW_FAULT : STAT_CAMERA_LOST;
          end else begin
            cmd.track = 1'b1;
          end
        end else if (!sts.hotkey) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_IDLE;
        end else if (!sts.camera) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_SKIP_NOCAM;
        end else if (!sts.yaw_ok) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_SKIP_NOYAW;
        end else if (sts.beacon) begin
          if (sts.pos_ok) begin
            cmd.offset = 1'b1;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_action = KEY_NONE;
            cmd.res_status = STAT_SKIP_NOPOS;
          end
        end else begin
          cmd.tgt_load = 1'b1;
          cmd.tgt_sel  = TGT_CARDINAL;
        end
      end
      ST_TRACK: begin
        cmd.track = 1'b1;
      end
      ST_PRODUCT: begin
        cmd.product = 1'b1;
      end
      ST_DECIDE: begin
        cmd.commit_track = 1'b1;
        cmd.res_load     = 1'b1;
        if (release_now) begin
          cmd.clear_active = 1'b1;
          cmd.res_action   = KEY_RELEASE;
          priority if (sts.arrived) cmd.res_status = STAT_ARRIVED;
          else if (sts.overshot)    cmd.res_status = STAT_OVERSHOT;
          else                      cmd.res_status = STAT_TIMEOUT;
        end else begin
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_ROTATING;
        end
      end
      ST_OFFSET: begin
        cmd.offset = 1'b1;
      end
      ST_PREROT: begin
        priority if (sts.coincident) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_SKIP_NOPOS;
        end else if (sts.zero_offset) begin
          cmd.tgt_load = 1'b1;
          cmd.tgt_sel  = TGT_ZERO;
        end else begin
          cmd.prerot = 1'b1;
          step_next  = '0;
        end
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
        step_next  = step + STEP_W'(1);
      end
      ST_ROUND: begin
        cmd.tgt_load = 1'b1;
        cmd.tgt_sel  = TGT_BEARING;
      end
      ST_AIM: begin
        cmd.res_load = 1'b1;
        if (sts.within_tol) begin
          cmd.res_action = KEY_NONE;
          cmd.res_status = STAT_AT_TARGET;
        end else begin
          cmd.arm        = 1'b1;
          cmd.res_action = KEY_PRESS;
          cmd.res_status = STAT_ARMED;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load      = 1'b1;
          result_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/predictive_yaw_rotation_controller_unit.sv =====
// channel  dir  handshake                    payload
// item     in   item_valid / item_stall      pyrc_pkg::in_item_t, one tick
// result   out  result_valid / result_stall  pyrc_pkg::out_item_t, one per tick
// config   in   psel penable pwrite pready   paddr[4:2] selects register, pwdata
//
// one tick in flight; a tick goes DECODE, then FINISH when idle, skipped early or on a
// release for lost camera or yaw, or first AIM on a cardinal target, OFFSET, PREROT on a
// coincident waypoint, TRACK, PRODUCT, DECIDE during a rotation, OFFSET, PREROT, AIM on a
// zero offset, OFFSET, PREROT, ROTATE, ROUND, AIM on a waypoint (one micro-rotation per
// cycle in the atan2 unit); the result sits in an output register, so the next tick enters
// while it waits and holds in its last cycle until that result is taken; rst is synchronous
module predictive_yaw_rotation_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  pyrc_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pyrc_pkg::out_item_t           result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pyrc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pyrc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;

  pyrc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pyrc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  pyrc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

endmodule

// ===== rtl/core/pyrc_checker.sv =====
`include "predictive_yaw_rotation_controller_unit_defines.svh"

module pyrc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input pyrc_pkg::out_item_t  result
);
  import pyrc_pkg::*;

  `PYRC_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
  `PYRC_ASSERT_NXT(a_no_instant_result, item_valid && !item_stall, !$rose(result_valid))
  `PYRC_ASSERT_IMP(a_active_status, result_valid && (result.status == STAT_ARMED || result.status == STAT_ROTATING), result.rotation_active)
  `PYRC_ASSERT_IMP(a_release_ends, result_valid && result.key_action == KEY_RELEASE, !result.rotation_active)

endmodule

bind predictive_yaw_rotation_controller_unit pyrc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
